// ===== rtl/core/bmafm_pkg.sv =====
// types, constants and widths shared by the minor-axis width pipeline
// no dependencies; imported by every module of rtl/core
package bmafm_pkg;

  // fraction bits of the width result and result width
  localparam int FRAC_BITS = 8;
  localparam int W_BITS    = 20;

  // scale of the outer radicand: 8 * 2^(2F) = 2^SH
  localparam int SH        = 3 + 2 * FRAC_BITS;

  // inner radicand d = 4*c^2 + dv^2 (all scaled by mass^2)
  localparam int D_BITS    = 171;
  // d scaled by 2^(2*SH), and its square root
  localparam int DD_BITS   = D_BITS + 2 * SH;
  localparam int R_BITS    = (DD_BITS + 1) / 2;
  localparam int RAD_BITS  = 2 * R_BITS;
  localparam int REM_BITS  = R_BITS + 2;

  // non-negative outer sum shifted by SH
  localparam int KS_BITS   = 85 + SH;
  localparam int M2_BITS   = 64;

  // compare width of the clamp test and the width search
  localparam int CB        = (R_BITS + 1 > KS_BITS) ? R_BITS + 1 : KS_BITS;
  localparam int PW        = ((KS_BITS > 104) ? KS_BITS : 104) + 2;

  // stream field widths
  localparam int IN_BITS   = 272;
  localparam int OUT_BITS  = 24;

  // side data carried along the square-root chain
  typedef struct packed {
    logic                neg;
    logic [KS_BITS-1:0]  ks;
    logic [M2_BITS-1:0]  m2;
  } pay_t;

  // square-root cell state
  typedef struct packed {
    logic                valid;
    logic [RAD_BITS-1:0] rad;
    logic [REM_BITS-1:0] rem;
    logic [R_BITS-1:0]   root;
    pay_t                pay;
  } sq_t;

  // width-search cell state
  typedef struct packed {
    logic                valid;
    logic                clamped;
    logic [KS_BITS-1:0]  v;
    logic [PW-1:0]       p;
    logic [PW-1:0]       qb;
    logic [PW-1:0]       mb;
    logic [W_BITS-1:0]   bm;
    logic [W_BITS-1:0]   w;
  } wc_t;

endpackage

// ===== rtl/core/blob_minor_axis_from_moments_top.sv =====
// stages: 9 front + R_BITS root cells + 1 entry + W_BITS width cells + 1 output,
// 136 register stages at 8 fraction bits (R_BITS = (209+1)/2 = 105)
// throughput: one request per cycle; the whole pipeline holds while a result waits
// reset: synchronous, clears all valid bits and the output valid
// top level of the minor-axis width pipeline; depends on bmafm_pkg, bmafm_front,
// bmafm_sqrt_cell and bmafm_width_cell
module blob_minor_axis_from_moments_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // mass[31:0], sum_x[73:32], sum_y[115:74], sum_xx[167:116],
  // sum_xy[219:168], sum_yy[271:220]
  input  logic [bmafm_pkg::IN_BITS-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // width[19:0], zero fill above
  output logic [bmafm_pkg::OUT_BITS-1:0]  m_tdata,
  // clamped[0]
  output logic                            m_tuser
);
  import bmafm_pkg::*;

  logic en;
  sq_t  sq [R_BITS+1];
  wc_t  wc [W_BITS+1];
  wc_t  wc0;
  logic [R_BITS:0] r_ceil;
  logic            clamp;
  logic [W_BITS-1:0] width_q;
  logic              clamped_q;

  // the pipeline advances unless a result is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  bmafm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .mass     (s_tdata[31:0]),
    .sum_x    (s_tdata[73:32]),
    .sum_y    (s_tdata[115:74]),
    .sum_xx   (s_tdata[167:116]),
    .sum_xy   (s_tdata[219:168]),
    .sum_yy   (s_tdata[271:220]),
    .sq_out   (sq[0])
  );

  // square-root chain
  for (genvar i = 0; i < R_BITS; i++) begin : g_sqrt
    bmafm_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .d_in (sq[i]),
      .q    (sq[i+1])
    );
  end

  // rounded-up root and clamp test
  always_comb begin
    r_ceil = (R_BITS+1)'(sq[R_BITS].root) + (R_BITS+1)'(sq[R_BITS].rem != '0);
    clamp  = sq[R_BITS].pay.neg || (CB'(sq[R_BITS].pay.ks) < CB'(r_ceil));
  end

  // width search entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      wc0.valid <= 1'b0;
    end else if (en) begin
      wc0.valid   <= sq[R_BITS].valid;
      wc0.clamped <= clamp;
      wc0.v       <= KS_BITS'(CB'(sq[R_BITS].pay.ks) - CB'(r_ceil));
      wc0.p       <= '0;
      wc0.qb      <= '0;
      wc0.mb      <= PW'(sq[R_BITS].pay.m2) << (2 * (W_BITS - 1));
      wc0.bm      <= W_BITS'(1) << (W_BITS - 1);
      wc0.w       <= '0;
    end
  end

  assign wc[0] = wc0;

  // width search chain
  for (genvar j = 0; j < W_BITS; j++) begin : g_width
    bmafm_width_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .d_in (wc[j]),
      .q    (wc[j+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= wc[W_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      width_q   <= wc[W_BITS].w;
      clamped_q <= wc[W_BITS].clamped;
    end
  end

  assign m_tdata = OUT_BITS'(width_q);
  assign m_tuser = clamped_q;

endmodule

// ===== rtl/core/bmafm_front.sv =====
// front pipeline: central moments, sum, difference and inner radicand
// depends on bmafm_pkg; feeds the first square-root cell
module bmafm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       mass,
  input  logic [41:0]       sum_x,
  input  logic [41:0]       sum_y,
  input  logic [51:0]       sum_xx,
  input  logic [51:0]       sum_xy,
  input  logic [51:0]       sum_yy,
  output bmafm_pkg::sq_t    sq_out
);
  import bmafm_pkg::*;

  // square of an 87-bit value from its limb products
  function automatic logic [171:0] sq_sum(input logic [57:0] p00, input logic [57:0] p01,
                                         input logic [57:0] p02, input logic [57:0] p11,
                                         input logic [57:0] p12, input logic [57:0] p22);
    sq_sum = (172'(p22) << 116) + (172'(p12) << 88) + (172'(p02) << 59)
           + (172'(p11) << 58) + (172'(p01) << 30) + 172'(p00);
  endfunction

  logic [8:0]  v;
  // stage 1
  logic [31:0] m1;
  logic [41:0] sx1, sy1;
  logic [51:0] sxx1, sxy1, syy1;
  // stage 2
  logic [57:0] pxl, pxh, pyl, pyh, pcl, pch;
  logic [41:0] xll, xlh, xhh, yll, ylh, yhh, cll, clh, chl, chh;
  logic [M2_BITS-1:0] m2_2, m2_3, m2_4, m2_5, m2_6, m2_7, m2_8, m2_9;
  // stage 3
  logic [83:0] mxx, myy, mxy, qxx, qyy, qxy;
  // stage 4
  logic [84:0] a4, b4, c4;
  // stage 5
  logic [85:0] sg5, dv5;
  logic [83:0] cabs5;
  // stage 6
  logic [85:0] sg6;
  logic [84:0] dvabs6;
  logic [83:0] cabs6;
  // stage 7
  logic [85:0] sg7;
  logic [57:0] c00, c01, c02, c11, c12, c22;
  logic [57:0] d00, d01, d02, d11, d12, d22;
  logic [86:0] cx, dx;
  // stage 8
  logic [85:0]  sg8;
  logic [171:0] c2, dv2;
  // stage 9
  logic [D_BITS-1:0]  d9;
  logic [KS_BITS-1:0] ks9;
  logic               neg9;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[7:0], in_valid};
    end
  end

  assign cx = {3'b000, cabs6};
  assign dx = {2'b00, dvabs6};

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      // capture, zero mass counts as one
      m1   <= (mass == 32'd0) ? 32'd1 : mass;
      sx1  <= sum_x;
      sy1  <= sum_y;
      sxx1 <= sum_xx;
      sxy1 <= sum_xy;
      syy1 <= sum_yy;
      // partial products
      pxl  <= 58'(m1) * 58'(sxx1[25:0]);
      pxh  <= 58'(m1) * 58'(sxx1[51:26]);
      pyl  <= 58'(m1) * 58'(syy1[25:0]);
      pyh  <= 58'(m1) * 58'(syy1[51:26]);
      pcl  <= 58'(m1) * 58'(sxy1[25:0]);
      pch  <= 58'(m1) * 58'(sxy1[51:26]);
      xll  <= 42'(sx1[20:0]) * 42'(sx1[20:0]);
      xlh  <= 42'(sx1[20:0]) * 42'(sx1[41:21]);
      xhh  <= 42'(sx1[41:21]) * 42'(sx1[41:21]);
      yll  <= 42'(sy1[20:0]) * 42'(sy1[20:0]);
      ylh  <= 42'(sy1[20:0]) * 42'(sy1[41:21]);
      yhh  <= 42'(sy1[41:21]) * 42'(sy1[41:21]);
      cll  <= 42'(sx1[20:0]) * 42'(sy1[20:0]);
      clh  <= 42'(sx1[20:0]) * 42'(sy1[41:21]);
      chl  <= 42'(sx1[41:21]) * 42'(sy1[20:0]);
      chh  <= 42'(sx1[41:21]) * 42'(sy1[41:21]);
      m2_2 <= 64'(m1) * 64'(m1);
      // full products
      mxx  <= (84'(pxh) << 26) + 84'(pxl);
      myy  <= (84'(pyh) << 26) + 84'(pyl);
      mxy  <= (84'(pch) << 26) + 84'(pcl);
      qxx  <= (84'(xhh) << 42) + (84'(xlh) << 22) + 84'(xll);
      qyy  <= (84'(yhh) << 42) + (84'(ylh) << 22) + 84'(yll);
      qxy  <= (84'(chh) << 42) + ((84'(clh) + 84'(chl)) << 21) + 84'(cll);
      m2_3 <= m2_2;
      // central moments scaled by mass^2
      a4   <= {1'b0, mxx} - {1'b0, qxx};
      b4   <= {1'b0, myy} - {1'b0, qyy};
      c4   <= {1'b0, mxy} - {1'b0, qxy};
      m2_4 <= m2_3;
      // sum, difference and magnitude of the mixed moment
      sg5   <= {a4[84], a4} + {b4[84], b4};
      dv5   <= {a4[84], a4} - {b4[84], b4};
      cabs5 <= c4[84] ? (~c4[83:0] + 84'd1) : c4[83:0];
      m2_5  <= m2_4;
      // magnitude of the difference
      dvabs6 <= dv5[85] ? (~dv5[84:0] + 85'd1) : dv5[84:0];
      cabs6  <= cabs5;
      sg6    <= sg5;
      m2_6   <= m2_5;
      // limb products of the two squares
      c00 <= 58'(cx[28:0])  * 58'(cx[28:0]);
      c01 <= 58'(cx[28:0])  * 58'(cx[57:29]);
      c02 <= 58'(cx[28:0])  * 58'(cx[86:58]);
      c11 <= 58'(cx[57:29]) * 58'(cx[57:29]);
      c12 <= 58'(cx[57:29]) * 58'(cx[86:58]);
      c22 <= 58'(cx[86:58]) * 58'(cx[86:58]);
      d00 <= 58'(dx[28:0])  * 58'(dx[28:0]);
      d01 <= 58'(dx[28:0])  * 58'(dx[57:29]);
      d02 <= 58'(dx[28:0])  * 58'(dx[86:58]);
      d11 <= 58'(dx[57:29]) * 58'(dx[57:29]);
      d12 <= 58'(dx[57:29]) * 58'(dx[86:58]);
      d22 <= 58'(dx[86:58]) * 58'(dx[86:58]);
      sg7  <= sg6;
      m2_7 <= m2_6;
      // squares
      c2   <= sq_sum(c00, c01, c02, c11, c12, c22);
      dv2  <= sq_sum(d00, d01, d02, d11, d12, d22);
      sg8  <= sg7;
      m2_8 <= m2_7;
      // inner radicand and shifted outer sum
      d9   <= D_BITS'((c2 << 2) + dv2);
      ks9  <= sg8[85] ? '0 : (KS_BITS'(sg8[84:0]) << SH);
      neg9 <= sg8[85];
      m2_9 <= m2_8;
    end
  end

  // start of the square-root chain
  always_comb begin
    sq_out.valid  = v[8];
    sq_out.rad    = RAD_BITS'(d9) << (2 * SH);
    sq_out.rem    = '0;
    sq_out.root   = '0;
    sq_out.pay.neg = neg9;
    sq_out.pay.ks  = ks9;
    sq_out.pay.m2  = m2_9;
  end

endmodule

// ===== rtl/core/bmafm_sqrt_cell.sv =====
// one root bit of the restoring square root of the scaled inner radicand
// depends on bmafm_pkg; chained R_BITS times in the top level
module bmafm_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  bmafm_pkg::sq_t  d_in,
  output bmafm_pkg::sq_t  q
);
  import bmafm_pkg::*;

  logic [REM_BITS-1:0] rem_sh;
  logic [REM_BITS-1:0] trial;
  logic                ge;
  sq_t                 q_next;

  // bring down two radicand bits and test the next root bit
  always_comb begin
    rem_sh = {d_in.rem[REM_BITS-3:0], d_in.rad[RAD_BITS-1 -: 2]};
    trial  = {d_in.root, 2'b01};
    ge     = (rem_sh >= trial);
    q_next        = d_in;
    q_next.rad    = {d_in.rad[RAD_BITS-3:0], 2'b00};
    q_next.rem    = ge ? (rem_sh - trial) : rem_sh;
    q_next.root   = {d_in.root[R_BITS-2:0], ge};
  end

  // cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/bmafm_width_cell.sv =====
// one bit of the width search: largest w with (w*mass)^2 <= v
// depends on bmafm_pkg; chained W_BITS times, most significant bit first
module bmafm_width_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  bmafm_pkg::wc_t  d_in,
  output bmafm_pkg::wc_t  q
);
  import bmafm_pkg::*;

  logic [PW-1:0] cand;
  logic          take;
  wc_t           q_next;

  // candidate square grows by 2^(b+1)*w*m2 + 2^(2b)*m2
  always_comb begin
    cand   = d_in.p + d_in.qb + d_in.mb;
    take   = !d_in.clamped && (cand <= PW'(d_in.v));
    q_next    = d_in;
    q_next.p  = take ? cand : d_in.p;
    q_next.qb = take ? ((d_in.qb >> 1) + d_in.mb) : (d_in.qb >> 1);
    q_next.mb = d_in.mb >> 2;
    q_next.bm = d_in.bm >> 1;
    q_next.w  = take ? (d_in.w | d_in.bm) : d_in.w;
  end

  // cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/bmafm_checker.sv =====
// port-level checks of the minor-axis width pipeline, bound to the top level
// depends on bmafm_pkg and blob_minor_axis_from_moments_top
module bmafm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [bmafm_pkg::IN_BITS-1:0]   s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [bmafm_pkg::OUT_BITS-1:0]  m_tdata,
  input  logic                            m_tuser
);
  import bmafm_pkg::*;

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("held result changed");

  // a clamped result carries zero width
  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("clamped result with nonzero width");

  // input stalls only behind a held result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a held result");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind blob_minor_axis_from_moments_top bmafm_checker u_bmafm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
